FILE: hw/rtl/vlsd_record_framer_defines.svh
// ----------------------------------------------------------------------------
// vlsd_record_framer_defines: assertion macros
// Shared shorthand for concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VLSD_RECORD_FRAMER_DEFINES_SVH
`define VLSD_RECORD_FRAMER_DEFINES_SVH

// same-cycle implication
`define VRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/vrf_pkg.sv
// ----------------------------------------------------------------------------
// vrf_pkg: shared types and constants of the VLSD record framer
// Command and status codes, job descriptor, config bundle, offset truncation.
// ----------------------------------------------------------------------------
package vrf_pkg;

  localparam int LENGTH_BYTES = 4;
  localparam int ID_BYTES_MAX = 8;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_BEGIN        = 2'd0,
    CMD_DATA         = 2'd1,
    CMD_CLEAR_OFFSET = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_NO_PENDING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_OFFSET_SIZE = 2'd0,
    CFG_ID_BYTES    = 2'd1,
    CFG_ID_VALUE    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    JOB_SINGLE = 1'b0,
    JOB_HEADER = 1'b1
  } job_kind_t;

  typedef struct packed {
    logic [1:0]  size_code;
    logic [3:0]  id_bytes;
    logic [63:0] id_value;
  } cfg_t;

  // one entry of the front-to-back queue
  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] len;
    logic [7:0]  data;
    logic        byte_valid;
    logic        rec_end;
    status_t     status;
    logic [63:0] offset;
    logic [63:0] count;
    logic [63:0] total;
  } job_t;

  function automatic logic [63:0] trunc_offset(input logic [63:0] v, input logic [1:0] code);
    logic [63:0] r;
    case (code)
      2'd0:    r = {56'd0, v[7:0]};
      2'd1:    r = {48'd0, v[15:0]};
      2'd2:    r = {32'd0, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/vlsd_record_framer.sv
// An item's first result passes the job queue and then the output register.
// While results are popped, data bytes go at 1 item per cycle; a begin in range
// holds the serializer for record_id_bytes (max 8) id bytes and 4 length bytes,
// one header byte per cycle. Input stalls only when the 2-entry queue is full.
// Reset (rst_n low, synchronous) clears offset, counters, queue and output valid;
// config returns to offset_size_code 2, record id size 0 and value 0.
// ----------------------------------------------------------------------------
// vlsd_record_framer: VLSD record framer top level
// Config registers, decode front, job queue and serializer back.
// ----------------------------------------------------------------------------
module vlsd_record_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_payload_length,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last,
  output logic        out_record_end,
  output logic [1:0]  out_status,
  output logic [63:0] out_offset_value,
  output logic [63:0] out_record_count,
  output logic [63:0] out_payload_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  vrf_pkg::cfg_t cfg_r, cfg_nxt;
  vrf_pkg::job_t front_job, head_job;
  logic          accept, job_push, job_pop, head_valid;

  assign cfg_ready = 1'b1;
  assign accept    = push & ~full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vrf_pkg::CFG_OFFSET_SIZE: cfg_nxt.size_code = cfg_data[1:0];
        vrf_pkg::CFG_ID_BYTES:    cfg_nxt.id_bytes  = cfg_data[3:0];
        vrf_pkg::CFG_ID_VALUE:    cfg_nxt.id_value  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_code <= 2'd2;
      cfg_r.id_bytes  <= 4'd0;
      cfg_r.id_value  <= 64'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vrf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .cmd            (in_cmd),
    .payload_length (in_payload_length),
    .data_byte      (in_data_byte),
    .cfg            (cfg_r),
    .job_push       (job_push),
    .job            (front_job)
  );

  vrf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (front_job),
    .full       (full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  vrf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head_valid        (head_valid),
    .head_job          (head_job),
    .job_pop           (job_pop),
    .pop               (pop),
    .empty             (empty),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last          (out_last),
    .out_record_end    (out_record_end),
    .out_status        (out_status),
    .out_offset_value  (out_offset_value),
    .out_record_count  (out_record_count),
    .out_payload_total (out_payload_total)
  );

endmodule

FILE: hw/rtl/vrf_front.sv
// ----------------------------------------------------------------------------
// vrf_front: command decode and record bookkeeping
// Checks offset range, advances counters and posts one job per result run.
// ----------------------------------------------------------------------------
module vrf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [1:0]    cmd,
  input  logic [31:0]   payload_length,
  input  logic [7:0]    data_byte,
  input  vrf_pkg::cfg_t cfg,
  output logic          job_push,
  output vrf_pkg::job_t job
);

  logic [63:0] run_off_r, run_off_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic [63:0] rec_cnt_r, rec_cnt_nxt;
  logic [63:0] pay_sum_r, pay_sum_nxt;
  logic [64:0] next_off;
  logic        ovf;

  assign next_off = {1'b0, run_off_r} + 65'(vrf_pkg::LENGTH_BYTES) + {33'd0, payload_length};

  always_comb begin
    case (cfg.size_code)
      2'd0:    ovf = |next_off[64:8];
      2'd1:    ovf = |next_off[64:16];
      2'd2:    ovf = |next_off[64:32];
      default: ovf = next_off[64] | (&next_off[63:0]);
    endcase
  end

  always_comb begin
    run_off_nxt    = run_off_r;
    pend_nxt       = pend_r;
    rec_cnt_nxt    = rec_cnt_r;
    pay_sum_nxt    = pay_sum_r;
    job_push       = 1'b0;
    job.kind       = vrf_pkg::JOB_SINGLE;
    job.len        = payload_length;
    job.data       = 8'd0;
    job.byte_valid = 1'b0;
    job.rec_end    = 1'b0;
    job.status     = vrf_pkg::ST_OK;
    job.offset     = vrf_pkg::trunc_offset(run_off_r, cfg.size_code);
    job.count      = rec_cnt_r;
    job.total      = pay_sum_r;
    if (accept) begin
      case (cmd)
        vrf_pkg::CMD_BEGIN: begin
          job_push = 1'b1;
          if (ovf) begin
            job.status = vrf_pkg::ST_OVERFLOW;
          end else begin
            job.kind    = vrf_pkg::JOB_HEADER;
            run_off_nxt = next_off[63:0];
            pend_nxt    = payload_length;
            rec_cnt_nxt = rec_cnt_r + 64'd1;
            pay_sum_nxt = pay_sum_r + {32'd0, payload_length};
            job.count   = rec_cnt_nxt;
            job.total   = pay_sum_nxt;
          end
        end
        vrf_pkg::CMD_DATA: begin
          job_push = 1'b1;
          if (pend_r == 32'd0) begin
            job.status = vrf_pkg::ST_NO_PENDING;
          end else begin
            pend_nxt       = pend_r - 32'd1;
            job.data       = data_byte;
            job.byte_valid = 1'b1;
            job.rec_end    = (pend_r == 32'd1);
          end
        end
        vrf_pkg::CMD_CLEAR_OFFSET: begin
          run_off_nxt = 64'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_off_r <= 64'd0;
      pend_r    <= 32'd0;
      rec_cnt_r <= 64'd0;
      pay_sum_r <= 64'd0;
    end else begin
      run_off_r <= run_off_nxt;
      pend_r    <= pend_nxt;
      rec_cnt_r <= rec_cnt_nxt;
      pay_sum_r <= pay_sum_nxt;
    end
  end

endmodule

FILE: hw/rtl/vrf_queue.sv
// ----------------------------------------------------------------------------
// vrf_queue: short job queue between front and back
// Register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module vrf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vrf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output vrf_pkg::job_t head_job
);

  vrf_pkg::job_t                mem_r [vrf_pkg::QDEPTH];
  logic [vrf_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [vrf_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [vrf_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign full       = (cnt_r == vrf_pkg::QCNT_W'(vrf_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  function automatic logic [vrf_pkg::QPTR_W-1:0] ptr_inc(input logic [vrf_pkg::QPTR_W-1:0] p);
    logic [vrf_pkg::QPTR_W-1:0] r;
    if (p == vrf_pkg::QPTR_W'(vrf_pkg::QDEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/vrf_back.sv
// ----------------------------------------------------------------------------
// vrf_back: result serializer
// Expands header jobs into id and length bytes; feeds the output register.
// ----------------------------------------------------------------------------
module vrf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  vrf_pkg::cfg_t  cfg,
  input  logic           head_valid,
  input  vrf_pkg::job_t  head_job,
  output logic           job_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           out_byte_valid,
  output logic           out_last,
  output logic           out_record_end,
  output logic [1:0]     out_status,
  output logic [63:0]    out_offset_value,
  output logic [63:0]    out_record_count,
  output logic [63:0]    out_payload_total
);

  logic [3:0]  beat_r, beat_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  byte_r;
  logic        bvalid_r, last_r, rend_r;
  logic [1:0]  status_r;
  logic [63:0] offset_r, count_r, total_r;

  logic [3:0]  idn, total_beats, len_idx;
  logic        load, last_beat;
  logic [7:0]  hdr_byte, res_byte;
  logic        res_valid, res_rend;
  logic [1:0]  res_status;

  assign idn         = (cfg.id_bytes > 4'(vrf_pkg::ID_BYTES_MAX)) ?
                       4'(vrf_pkg::ID_BYTES_MAX) : cfg.id_bytes;
  assign total_beats = idn + 4'(vrf_pkg::LENGTH_BYTES);
  assign len_idx     = beat_r - idn;
  assign last_beat   = (head_job.kind == vrf_pkg::JOB_SINGLE) ||
                       (beat_r == total_beats - 4'd1);
  assign load        = head_valid & (~ovalid_r | pop);
  assign job_pop     = load & last_beat;

  always_comb begin
    if (beat_r < idn) hdr_byte = cfg.id_value[beat_r[2:0]*8 +: 8];
    else hdr_byte = head_job.len[len_idx[1:0]*8 +: 8];
  end

  always_comb begin
    if (head_job.kind == vrf_pkg::JOB_HEADER) begin
      res_byte   = hdr_byte;
      res_valid  = 1'b1;
      res_rend   = last_beat && (head_job.len == 32'd0);
      res_status = vrf_pkg::ST_OK;
    end else begin
      res_byte   = head_job.data;
      res_valid  = head_job.byte_valid;
      res_rend   = head_job.rec_end;
      res_status = head_job.status;
    end
  end

  always_comb begin
    beat_nxt   = beat_r;
    ovalid_nxt = ovalid_r;
    if (pop && ovalid_r) ovalid_nxt = 1'b0;
    if (load) begin
      ovalid_nxt = 1'b1;
      beat_nxt   = last_beat ? 4'd0 : beat_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r   <= 4'd0;
      ovalid_r <= 1'b0;
    end else begin
      beat_r   <= beat_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= res_byte;
      bvalid_r <= res_valid;
      last_r   <= last_beat;
      rend_r   <= res_rend;
      status_r <= res_status;
      offset_r <= head_job.offset;
      count_r  <= head_job.count;
      total_r  <= head_job.total;
    end
  end

  assign empty             = ~ovalid_r;
  assign out_byte          = byte_r;
  assign out_byte_valid    = bvalid_r;
  assign out_last          = last_r;
  assign out_record_end    = rend_r;
  assign out_status        = status_r;
  assign out_offset_value  = offset_r;
  assign out_record_count  = count_r;
  assign out_payload_total = total_r;

endmodule

FILE: hw/rtl/vrf_checker.sv
// ----------------------------------------------------------------------------
// vrf_checker: port-level checks for the VLSD record framer
// Result consistency and output hold; bound to the top level.
// ----------------------------------------------------------------------------
`include "vlsd_record_framer_defines.svh"

module vrf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_last,
  input logic       out_record_end,
  input logic [1:0] out_status
);

  `VRF_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(out_last), "result changed while stalled")
  `VRF_ASSERT_NOW(a_no_byte, !empty && !out_byte_valid, out_byte == 8'd0 && out_last, "empty result not a single last with zero byte")
  `VRF_ASSERT_NOW(a_err, !empty && out_status != vrf_pkg::ST_OK, !out_byte_valid && !out_record_end, "error result carries a byte")
  `VRF_ASSERT_NOW(a_rec_end, !empty && out_record_end, out_last && out_byte_valid, "record end not on last valid byte")

endmodule

bind vlsd_record_framer vrf_checker u_vrf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .empty          (empty),
  .pop            (pop),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_last       (out_last),
  .out_record_end (out_record_end),
  .out_status     (out_status)
);
